[design/parachute_deploy_detector_unit_assert.svh]
// assertion macros shared by the detector modules
`ifndef PARACHUTE_DEPLOY_DETECTOR_UNIT_ASSERT_SVH
`define PARACHUTE_DEPLOY_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pdd_pkg.sv]
// shared types and register indexes for the parachute deploy detector
package pdd_pkg;

  localparam int unsigned ALT_W  = 32;
  localparam int unsigned BAND_W = 31;
  localparam int unsigned CONF_W = 6;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    CFG_MAIN_CENTER_OFFSET = 2'd0,
    CFG_MAIN_DEPLOY_BAND   = 2'd1,
    CFG_DROGUE_DROP_LIMIT  = 2'd2,
    CFG_DROGUE_CONFIDENCE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ALT_W-1:0] center_offset;
    logic [BAND_W-1:0]       deploy_band;
  } main_cfg_t;

  typedef struct packed {
    logic signed [ALT_W-1:0] drop_limit;
    logic [CONF_W-1:0]       confidence;
  } drogue_cfg_t;

endpackage

[design/pdd_main_win.sv]
// main window: in-band flags, running count and fire decision
module pdd_main_win #(
  parameter int unsigned WIN = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            upd,
  input  logic signed [pdd_pkg::ALT_W-1:0] alt,
  input  pdd_pkg::main_cfg_t              cfg,
  output logic                            fire
);
  import pdd_pkg::*;

  localparam int unsigned SLOT_W = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int unsigned CNT_W  = $clog2(WIN + 1);

  logic [WIN-1:0]    flags_r, flags_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic signed [ALT_W:0] diff;
  logic [ALT_W:0]        mag;
  logic                  in_band;
  logic                  old_flag;

  always_comb begin
    diff    = {alt[ALT_W-1], alt} - {cfg.center_offset[ALT_W-1], cfg.center_offset};
    mag     = diff[ALT_W] ? (~diff + 1'b1) : diff;
    in_band = mag < {{(ALT_W + 1 - BAND_W){1'b0}}, cfg.deploy_band};
    old_flag = flags_r[slot_r];

    flags_nxt         = flags_r;
    flags_nxt[slot_r] = in_band;
    count_nxt = count_r - CNT_W'(old_flag) + CNT_W'(in_band);
    slot_nxt  = (slot_r == SLOT_W'(WIN - 1)) ? '0 : slot_r + 1'b1;
    fire      = (count_nxt == CNT_W'(WIN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      slot_r  <= '0;
      count_r <= '0;
    end else if (upd) begin
      flags_r <= flags_nxt;
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
    end
  end

`include "parachute_deploy_detector_unit_assert.svh"
  `PDD_ASSERT_NOW(a_main_count_tracks, 1'b1, count_r == CNT_W'($countones(flags_r)), "main count out of step with flags")
  `PDD_ASSERT_NEXT(a_main_fire_full, upd && fire, &flags_r, "main fired without a full window")
  `PDD_ASSERT_NOW(a_main_slot_range, 1'b1, slot_r <= SLOT_W'(WIN - 1), "main slot beyond window")

endmodule

[design/pdd_drogue_win.sv]
// drogue window: descent flags, running count and fire decision
module pdd_drogue_win #(
  parameter int unsigned WIN = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             upd,
  input  logic signed [pdd_pkg::ALT_W-1:0] alt,
  input  pdd_pkg::drogue_cfg_t             cfg,
  output logic                             fire
);
  import pdd_pkg::*;

  localparam int unsigned SLOT_W = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int unsigned CNT_W  = $clog2(WIN + 1);
  localparam int unsigned CMP_W  = (CNT_W > CONF_W) ? CNT_W : CONF_W;

  logic [WIN-1:0]          flags_r, flags_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt, count_ret;
  logic signed [ALT_W-1:0] prev_r, prev_nxt;

  logic signed [ALT_W:0] drop;
  logic                  descending;

  always_comb begin
    // retire the expiring slot before judging confidence
    count_ret = count_r - CNT_W'(flags_r[slot_r]);
    drop      = {prev_r[ALT_W-1], prev_r} - {alt[ALT_W-1], alt};
    descending = drop > $signed({cfg.drop_limit[ALT_W-1], cfg.drop_limit});

    fire              = CMP_W'(count_ret) > CMP_W'(cfg.confidence);
    flags_nxt         = flags_r;
    flags_nxt[slot_r] = 1'b0;
    count_nxt         = count_ret;
    prev_nxt          = prev_r;
    if (!fire) begin
      flags_nxt[slot_r] = descending;
      count_nxt         = count_ret + CNT_W'(descending);
      prev_nxt          = alt;
    end
    slot_nxt = (slot_r == SLOT_W'(WIN - 1)) ? '0 : slot_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      slot_r  <= '0;
      count_r <= '0;
      prev_r  <= '0;
    end else if (upd) begin
      flags_r <= flags_nxt;
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
    end
  end

`include "parachute_deploy_detector_unit_assert.svh"
  `PDD_ASSERT_NOW(a_drop_count_tracks, 1'b1, count_r == CNT_W'($countones(flags_r)), "drop count out of step with flags")
  `PDD_ASSERT_NEXT(a_drop_fire_holds_prev, upd && fire, $stable(prev_r), "previous altitude moved on a drogue fire")
  `PDD_ASSERT_NEXT(a_drop_fire_clears, upd && fire, count_r == $past(count_ret), "drop flag set on a drogue fire")

endmodule

[design/parachute_deploy_detector_unit.sv]
// top level of the parachute deploy detector
// path: an accepted word is held in the input register, then in the result register that drives out_
// throughput: one word per cycle; while a result waits the input register
//   takes one more word and then the input stalls
// reset: rst_n synchronous active low; clears config, valid flags, both flag
//   windows, slot and count state and the previous altitude
module parachute_deploy_detector_unit #(
  parameter int unsigned MAIN_WINDOW   = 16,
  parameter int unsigned DROGUE_WINDOW = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [pdd_pkg::ALT_W-1:0] in_altitude_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_drogue_fire,
  output logic                             out_main_fire,
  input  logic                             cfg_we,
  input  logic [pdd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pdd_pkg::ALT_W-1:0]        cfg_wdata
);
  import pdd_pkg::*;

  main_cfg_t   main_cfg_r;
  drogue_cfg_t drogue_cfg_r;

  logic                    s1_valid_r;
  logic signed [ALT_W-1:0] alt_r;
  logic                    out_valid_r, drogue_r, main_r;
  logic                    advance;
  logic                    main_fire, drogue_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_cfg_r   <= '0;
      drogue_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAIN_CENTER_OFFSET: main_cfg_r.center_offset  <= cfg_wdata;
        CFG_MAIN_DEPLOY_BAND:   main_cfg_r.deploy_band    <= cfg_wdata[BAND_W-1:0];
        CFG_DROGUE_DROP_LIMIT:  drogue_cfg_r.drop_limit   <= cfg_wdata;
        CFG_DROGUE_CONFIDENCE:  drogue_cfg_r.confidence   <= cfg_wdata[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // the result register moves when empty or being taken
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      alt_r <= in_altitude_sample;
    end
  end

  pdd_main_win #(
    .WIN (MAIN_WINDOW)
  ) u_main (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s1_valid_r && advance),
    .alt   (alt_r),
    .cfg   (main_cfg_r),
    .fire  (main_fire)
  );

  pdd_drogue_win #(
    .WIN (DROGUE_WINDOW)
  ) u_drogue (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s1_valid_r && advance),
    .alt   (alt_r),
    .cfg   (drogue_cfg_r),
    .fire  (drogue_fire)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      drogue_r <= drogue_fire;
      main_r   <= main_fire;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drogue_fire = drogue_r;
  assign out_main_fire   = main_r;

`include "parachute_deploy_detector_unit_assert.svh"
  `PDD_ASSERT_NOW(a_stall_only_when_full, !in_ready, s1_valid_r && out_valid_r && !out_ready, "input stalled with room downstream")
  `PDD_ASSERT_NEXT(a_word_reaches_out, s1_valid_r && advance, out_valid_r, "word lost between input and result register")
  `PDD_ASSERT_NEXT(a_held_word_stable, s1_valid_r && !advance, s1_valid_r && $stable(alt_r), "held input word changed while stalled")

endmodule
